>>> src/shhs_pkg.sv
package shhs_pkg;

   localparam int STEP_W  = 14;
   localparam int WAIT_W  = 4;
   localparam int PHASE_W = 3;
   localparam int COIL_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_WAIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_WAIT   = 2'd3;

   // register reset values
   localparam logic [STEP_W-1:0] BACK_LIMIT_RST = 14'd10000;
   localparam logic [STEP_W-1:0] FWD_LIMIT_RST  = 14'd5000;
   localparam logic [WAIT_W-1:0] BACK_WAIT_RST  = 4'd2;
   localparam logic [WAIT_W-1:0] FWD_WAIT_RST   = 4'd6;

   // command codes
   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_STEP_FWD = 2'd1;
   localparam logic [1:0] MODE_STEP_BWD = 2'd2;
   localparam logic [1:0] MODE_HOME     = 2'd3;

   typedef enum logic [1:0] {
      LEG_IDLE = 2'd0,
      LEG_BACK = 2'd1,
      LEG_FWD  = 2'd2
   } leg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       home_sensor;
   } req_type;

   typedef struct packed {
      logic [COIL_W-1:0]  coil_pattern;
      logic [PHASE_W-1:0] phase;
      logic               busy_res;
      logic               home_done;
      logic               back_timeout;
      logic               fwd_timeout;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] back_limit;
      logic [STEP_W-1:0] fwd_limit;
      logic [WAIT_W-1:0] back_wait;
      logic [WAIT_W-1:0] fwd_wait;
   } cfg_type;

   // standard half-step coil table
   function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
      logic [COIL_W-1:0] c;
      case (ph)
         3'd0:    c = 4'h1;
         3'd1:    c = 4'h3;
         3'd2:    c = 4'h2;
         3'd3:    c = 4'h6;
         3'd4:    c = 4'h4;
         3'd5:    c = 4'hC;
         3'd6:    c = 4'h8;
         default: c = 4'h9;
      endcase
      return c;
   endfunction

endpackage

>>> src/shhs_csr.sv
module shhs_csr
   import shhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.back_limit <= BACK_LIMIT_RST;
         cfg_ff.fwd_limit  <= FWD_LIMIT_RST;
         cfg_ff.back_wait  <= BACK_WAIT_RST;
         cfg_ff.fwd_wait   <= FWD_WAIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BACK_LIMIT: cfg_ff.back_limit <= csr_wdata;
            CSR_FWD_LIMIT:  cfg_ff.fwd_limit  <= csr_wdata;
            CSR_BACK_WAIT:  cfg_ff.back_wait  <= csr_wdata[WAIT_W-1:0];
            CSR_FWD_WAIT:   cfg_ff.fwd_wait   <= csr_wdata[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/shhs_core.sv
module shhs_core
   import shhs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               coils_on_ff, coils_on_in;
   leg_type            leg_ff, leg_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic               back_to_ff, back_to_in;
   logic               fwd_to_ff, fwd_to_in;

   logic              homing, start, wait_tick, eval;
   leg_type           cur_leg;
   logic [STEP_W-1:0] steps_cur, fwd_steps;
   logic              back_step, back_end, fwd_eval, fwd_step, fwd_end;
   logic              back_hit, fwd_hit, move_fwd, move_bwd;

   assign homing    = (leg_ff == LEG_BACK) || (leg_ff == LEG_FWD);
   assign start     = !homing && (req.mode == MODE_HOME);
   assign wait_tick = homing && (wait_ff != '0);
   assign eval      = start || (homing && (wait_ff == '0));
   assign cur_leg   = start ? LEG_BACK : leg_ff;
   assign steps_cur = start ? '0 : steps_ff;

   // leg one, then leg two in the same tick once leg one ends
   assign back_step = eval && (cur_leg == LEG_BACK) && !req.home_sensor
                      && (steps_cur < cfg.back_limit);
   assign back_end  = eval && (cur_leg == LEG_BACK) && !back_step;
   assign back_hit  = back_end && (steps_cur >= cfg.back_limit);
   assign fwd_eval  = eval && ((cur_leg == LEG_FWD) || back_end);
   assign fwd_steps = back_end ? '0 : steps_cur;
   assign fwd_step  = fwd_eval && req.home_sensor && (fwd_steps < cfg.fwd_limit);
   assign fwd_end   = fwd_eval && !fwd_step;
   assign fwd_hit   = fwd_end && (fwd_steps >= cfg.fwd_limit);

   assign move_fwd = (!homing && (req.mode == MODE_STEP_FWD)) || fwd_step;
   assign move_bwd = (!homing && (req.mode == MODE_STEP_BWD)) || back_step;

   // leg sequencing
   always_comb begin
      leg_in = homing ? leg_ff : LEG_IDLE;
      if (start)    leg_in = LEG_BACK;
      if (back_end) leg_in = LEG_FWD;
      if (fwd_end)  leg_in = LEG_IDLE;
   end

   // counters, phase and flags
   always_comb begin
      steps_in = steps_ff;
      if (start)     steps_in = '0;
      if (back_step) steps_in = steps_cur + 1'b1;
      if (back_end)  steps_in = '0;
      if (fwd_step)  steps_in = fwd_steps + 1'b1;
      if (fwd_end)   steps_in = '0;

      wait_in = wait_ff;
      if (wait_tick)     wait_in = wait_ff - 1'b1;
      else if (back_step) wait_in = cfg.back_wait;
      else if (fwd_step)  wait_in = cfg.fwd_wait;
      else if (start || fwd_end) wait_in = '0;

      back_to_in = (back_to_ff && !start) || back_hit;
      fwd_to_in  = (fwd_to_ff && !start) || fwd_hit;

      phase_in = phase_ff;
      if (move_fwd)      phase_in = phase_ff + 1'b1;
      else if (move_bwd) phase_in = phase_ff - 1'b1;
      coils_on_in = coils_on_ff || move_fwd || move_bwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         coils_on_ff <= 1'b0;
         leg_ff      <= LEG_IDLE;
         steps_ff    <= '0;
         wait_ff     <= '0;
         back_to_ff  <= 1'b0;
         fwd_to_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         coils_on_ff <= coils_on_in;
         leg_ff      <= leg_in;
         steps_ff    <= steps_in;
         wait_ff     <= wait_in;
         back_to_ff  <= back_to_in;
         fwd_to_ff   <= fwd_to_in;
      end
   end

   always_comb begin
      rsp.coil_pattern = coils_on_in ? coil_of(phase_in) : '0;
      rsp.phase        = phase_in;
      rsp.busy_res     = (leg_in != LEG_IDLE);
      rsp.home_done    = fwd_end;
      rsp.back_timeout = back_to_in;
      rsp.fwd_timeout  = fwd_to_in;
   end

endmodule

>>> src/stepper_half_step_homing_unit.sv
// half-step stepper sequencer with two-leg homing
//
// req channel: one transaction per time tick, carrying a command (idle,
// step forward, step backward, start homing) and the home switch level.
// rsp channel: exactly one transaction per request, in order, carrying the
// coil drive bits, phase, busy, done and the two leg timeout flags.
// csr port: plain write port (enable, index, data), no read-back; write
// only while no request is still in flight.
// flow: a request lands in the input register when it is accepted and is
// evaluated there against the sequencer state; the result is then captured
// in the result register, which drives rsp_valid and rsp_data, and the rsp
// transaction completes when rsp_ready is high.
// throughput: one transaction per clock while rsp_ready stays high, as the
// state update between the input and result registers is combinational.
// reset (synchronous): both registers empty, phase 0, coils off, homing
// idle, flags clear, csr registers back to their defaults.
// stall: when rsp_ready is low the result holds; the input register still
// takes one more request, after which req_ready drops until rsp drains.
module stepper_half_step_homing_unit
   import shhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    advance;

   // evaluate the held request when the result slot is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   shhs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   shhs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/shhs_checker.sv
module shhs_checker
   import shhs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic [PHASE_W-1:0] last_phase_ff;
   logic [PHASE_W-1:0] phase_delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_phase_ff <= rsp_data.phase;
      end
   end

   assign phase_delta = rsp_data.phase - last_phase_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.home_done |-> !rsp_data.busy_res)
      else $error("homing done while still busy");

   a_coil_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.coil_pattern != '0)
      |-> rsp_data.coil_pattern == coil_of(rsp_data.phase))
      else $error("coil bits do not match phase");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (phase_delta == 3'd0) || (phase_delta == 3'd1)
                    || (phase_delta == 3'd7))
      else $error("phase moved more than one half-step");

endmodule

bind stepper_half_step_homing_unit shhs_checker u_shhs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/shhs_homing_checker.sv
`timescale 1ns / 100ps
module shhs_homing_checker
   import shhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    results_owed
);

   // half-step coil drive, phase 0 in the low nibble
   localparam logic [8*COIL_W-1:0] COIL_SEQ = 32'h9_8_C_4_6_2_3_1;

   cfg_type            cfg;
   logic [PHASE_W-1:0] ph;
   logic [COIL_W-1:0]  coils;
   leg_type            leg;
   logic [STEP_W-1:0]  leg_steps;
   logic [WAIT_W-1:0]  wait_left;
   logic               back_to;
   logic               fwd_to;
   rsp_type            tick_results[$];

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
   end

   task automatic move_one(input logic backward);
      ph    = backward ? ph - 1'b1 : ph + 1'b1;
      coils = COIL_SEQ[ph*COIL_W +: COIL_W];
   endtask

   task automatic homing_tick(input logic sensor, output logic done);
      done = 1'b0;
      if (wait_left != '0) begin
         wait_left = wait_left - 1'b1;
      end else begin
         if (leg == LEG_BACK) begin
            if (!sensor && leg_steps < cfg.back_limit) begin
               move_one(1'b1);
               leg_steps = leg_steps + 1'b1;
               wait_left = cfg.back_wait;
            end else begin
               if (leg_steps >= cfg.back_limit) back_to = 1'b1;
               leg       = LEG_FWD;
               leg_steps = '0;
            end
         end
         // leg two is evaluated in the same tick that leg one ends
         if (leg == LEG_FWD) begin
            if (sensor && leg_steps < cfg.fwd_limit) begin
               move_one(1'b0);
               leg_steps = leg_steps + 1'b1;
               wait_left = cfg.fwd_wait;
            end else begin
               if (leg_steps >= cfg.fwd_limit) fwd_to = 1'b1;
               leg       = LEG_IDLE;
               leg_steps = '0;
               wait_left = '0;
               done      = 1'b1;
            end
         end
      end
   endtask

   task automatic advance_sequencer(input req_type r, output rsp_type o);
      logic done;
      done = 1'b0;
      if (leg == LEG_IDLE) begin
         case (r.mode)
            MODE_STEP_FWD: move_one(1'b0);
            MODE_STEP_BWD: move_one(1'b1);
            MODE_HOME: begin
               leg       = LEG_BACK;
               leg_steps = '0;
               wait_left = '0;
               back_to   = 1'b0;
               fwd_to    = 1'b0;
               homing_tick(r.home_sensor, done);
            end
            default: ;
         endcase
      end else begin
         homing_tick(r.home_sensor, done);
      end
      o.coil_pattern = coils;
      o.phase        = ph;
      o.busy_res     = (leg != LEG_IDLE);
      o.home_done    = done;
      o.back_timeout = back_to;
      o.fwd_timeout  = fwd_to;
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg.back_limit = BACK_LIMIT_RST;
         cfg.fwd_limit  = FWD_LIMIT_RST;
         cfg.back_wait  = BACK_WAIT_RST;
         cfg.fwd_wait   = FWD_WAIT_RST;
         ph        = '0;
         coils     = '0;
         leg       = LEG_IDLE;
         leg_steps = '0;
         wait_left = '0;
         back_to   = 1'b0;
         fwd_to    = 1'b0;
         tick_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BACK_LIMIT: cfg.back_limit = csr_wdata;
               CSR_FWD_LIMIT:  cfg.fwd_limit  = csr_wdata;
               CSR_BACK_WAIT:  cfg.back_wait  = csr_wdata[WAIT_W-1:0];
               CSR_FWD_WAIT:   cfg.fwd_wait   = csr_wdata[WAIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_sequencer(req_data, want);
            tick_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (tick_results.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, got %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = tick_results.pop_front();
               check_field("coil_pattern", want.coil_pattern, rsp_data.coil_pattern);
               check_field("phase",        want.phase,        rsp_data.phase);
               check_field("busy_res",     want.busy_res,     rsp_data.busy_res);
               check_field("home_done",    want.home_done,    rsp_data.home_done);
               check_field("back_timeout", want.back_timeout, rsp_data.back_timeout);
               check_field("fwd_timeout",  want.fwd_timeout,  rsp_data.fwd_timeout);
            end
         end
      end
      results_owed = tick_results.size();
   end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import shhs_pkg::*;

   // every input known from time zero, reset held high
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          mismatch_count;
   int          results_owed;
   int unsigned idle_pct    = 0;   // chance of a sender gap per tick
   int unsigned stall_pct   = 0;   // chance of receiver back-pressure per cycle
   int unsigned phase_ticks = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stepper_half_step_homing_unit u_dut (.*);

   shhs_homing_checker u_checker (.*);

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // hard stop in case the handshake hangs
   initial begin : watchdog
      #2_000_000;
      $display("** stepper_half_step_homing_unit: FAILED **");
      $finish;
   end

   // one time tick: optional gap, then hold valid until the transaction is taken
   task automatic send_tick(input logic [1:0] mode, input logic sensor);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, home_sensor: sensor};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      phase_ticks++;
   endtask

   // stop sending and let every owed result drain, then a few spare cycles
   task automatic settle(input int spare);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (spare) @(negedge clock);
   endtask

   // back-to-back register writes, enable dropped once at the end
   task automatic program_regs(input cfg_type c);
      csr_write <= 1'b1;
      csr_index <= CSR_BACK_LIMIT;
      csr_wdata <= c.back_limit;
      @(negedge clock);
      csr_index <= CSR_FWD_LIMIT;
      csr_wdata <= c.fwd_limit;
      @(negedge clock);
      csr_index <= CSR_BACK_WAIT;
      csr_wdata <= CSR_DATA_W'(c.back_wait);
      @(negedge clock);
      csr_index <= CSR_FWD_WAIT;
      csr_wdata <= CSR_DATA_W'(c.fwd_wait);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // switch level with the odd bounce
   function automatic logic bouncy(input logic level);
      return ($urandom_range(19) == 0) ? ~level : level;
   endfunction

   // a well-formed homing run: open switch, pressed switch, released again;
   // commands in between are random and should be ignored while busy
   task automatic homing_run();
      int unsigned n;
      send_tick(MODE_HOME, 1'($urandom_range(1)));
      n = $urandom_range(12);
      repeat (n) send_tick(2'($urandom_range(3)), bouncy(1'b0));
      n = $urandom_range(12);
      repeat (n) send_tick(2'($urandom_range(3)), bouncy(1'b1));
      n = $urandom_range(8);
      repeat (n) send_tick(2'($urandom_range(3)), bouncy(1'b0));
   endtask

   initial begin : stimulus
      cfg_type c;
      int unsigned burst;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part, register defaults
      // coils stay off until the first step
      send_tick(MODE_IDLE, 1'b0);
      send_tick(MODE_IDLE, 1'b1);
      // backward wraps phase 0 to 7, forward wraps back
      send_tick(MODE_STEP_BWD, 1'b0);
      send_tick(MODE_STEP_FWD, 1'b1);
      send_tick(MODE_STEP_FWD, 1'b0);
      // homing on a pressed switch: leg one ends at once, leg two steps in the same tick
      send_tick(MODE_HOME, 1'b1);
      // forward wait, manual commands and a second start all ignored
      send_tick(MODE_STEP_FWD, 1'b1);
      send_tick(MODE_STEP_BWD, 1'b1);
      send_tick(MODE_HOME, 1'b1);
      send_tick(MODE_IDLE, 1'b1);
      send_tick(MODE_STEP_FWD, 1'b0);
      send_tick(MODE_STEP_BWD, 1'b0);
      // switch released: homing completes
      send_tick(MODE_IDLE, 1'b0);
      // homing from an open switch: backward step, then the backward wait
      send_tick(MODE_HOME, 1'b0);
      send_tick(MODE_IDLE, 1'b0);
      send_tick(MODE_IDLE, 1'b0);
      // switch pressed: leg change and a forward step in one tick
      send_tick(MODE_STEP_BWD, 1'b1);
      repeat (6) send_tick(MODE_IDLE, 1'b1);
      send_tick(MODE_IDLE, 1'b0);

      // random phases, each with its own register setting and idling mix
      for (int p = 0; p < 8; p++) begin
         settle(4);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         if (p == 0) begin
            // zero limits: both legs time out in the start tick
            c = '0;
         end else if (p == 1) begin
            c = '{back_limit: '1, fwd_limit: '1, back_wait: '1, fwd_wait: '1};
         end else begin
            // mostly short limits so the timeouts are reached
            c.back_limit = ($urandom_range(3) == 0) ? STEP_W'($urandom_range(16383))
                                                    : STEP_W'($urandom_range(6));
            c.fwd_limit  = ($urandom_range(3) == 0) ? STEP_W'($urandom_range(16383))
                                                    : STEP_W'($urandom_range(6));
            c.back_wait  = ($urandom_range(1) == 0) ? WAIT_W'($urandom_range(2))
                                                    : WAIT_W'($urandom_range(15));
            c.fwd_wait   = ($urandom_range(1) == 0) ? WAIT_W'($urandom_range(2))
                                                    : WAIT_W'($urandom_range(15));
         end
         program_regs(c);
         phase_ticks = 0;
         while (phase_ticks < 100) begin
            if ($urandom_range(99) < 70) begin
               homing_run();
            end else begin
               // unstructured noise
               burst = $urandom_range(1, 6);
               repeat (burst) send_tick(2'($urandom_range(3)), 1'($urandom_range(1)));
            end
         end
      end

      settle(8);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("** stepper_half_step_homing_unit: PASSED **");
      end else begin
         $display("** stepper_half_step_homing_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> stepper_half_step_homing_unit.f
src/shhs_pkg.sv
src/shhs_csr.sv
src/shhs_core.sv
src/stepper_half_step_homing_unit.sv
src/shhs_checker.sv
verif/shhs_homing_checker.sv
verif/tb_top.sv
